// ----- design/qtoe_pkg.sv -----
// shared types and constants for the quadtree tile-of-extent block
package qtoe_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int REL_W     = COORD_W + 1;
    localparam int SIDE_W    = 31;
    localparam int TILE_W    = 16;
    localparam int LVL_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 4 * COORD_W;
    localparam int M_DATA_W  = 40;

    // default tree depth
    localparam int MAX_LEVEL_DEF = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 2'd0,
        CFG_ORIGIN_Y  = 2'd1,
        CFG_BASE_SIDE = 2'd2
    } cfg_idx_t;

    // slots of the edge numerator bundle
    localparam int NUM_LO_X = 0;
    localparam int NUM_HI_X = 1;
    localparam int NUM_LO_Y = 2;
    localparam int NUM_HI_Y = 3;
    localparam int NUM_CNT  = 4;

    // box relative to the root origin plus the descent so far
    typedef struct packed {
        logic signed [REL_W-1:0] rel_min_x;
        logic signed [REL_W-1:0] rel_min_y;
        logic signed [REL_W-1:0] rel_max_x;
        logic signed [REL_W-1:0] rel_max_y;
        logic [TILE_W-1:0]       tile_x;
        logic [TILE_W-1:0]       tile_y;
        logic [LVL_W-1:0]        level;
        logic                    done;
    } item_t;

endpackage

// ----- design/qtoe_entry.sv -----
// entry stage: box made relative to the origin, root tile edges loaded
module qtoe_entry #(
    parameter int MAX_LEVEL = qtoe_pkg::MAX_LEVEL_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  origin_x,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  origin_y,
    input  logic [qtoe_pkg::SIDE_W-1:0]          base_side,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  min_x,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  min_y,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  max_x,
    input  logic signed [qtoe_pkg::COORD_W-1:0]  max_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qtoe_pkg::item_t                      out_item,
    output logic [qtoe_pkg::NUM_CNT-1:0][qtoe_pkg::SIDE_W+MAX_LEVEL-1:0] out_num
);
    import qtoe_pkg::*;

    localparam int NW = SIDE_W + MAX_LEVEL;

    logic                            valid_reg;
    item_t                           item_reg;
    item_t                           item_next;
    logic [NUM_CNT-1:0][NW-1:0]      num_reg;
    logic [NUM_CNT-1:0][NW-1:0]      num_next;
    logic [NW-1:0]                   root_hi;
    logic                            load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // root tile spans [0, side] scaled by 2^MAX_LEVEL
    assign root_hi = NW'(base_side) << MAX_LEVEL;

    // subtract the origin once so cells compare against plain offsets
    always_comb begin
        item_next.rel_min_x = REL_W'(min_x) - REL_W'(origin_x);
        item_next.rel_min_y = REL_W'(min_y) - REL_W'(origin_y);
        item_next.rel_max_x = REL_W'(max_x) - REL_W'(origin_x);
        item_next.rel_max_y = REL_W'(max_y) - REL_W'(origin_y);
        item_next.tile_x    = '0;
        item_next.tile_y    = '0;
        item_next.level     = '0;
        item_next.done      = 1'b0;
        num_next[NUM_LO_X]  = '0;
        num_next[NUM_HI_X]  = root_hi;
        num_next[NUM_LO_Y]  = '0;
        num_next[NUM_HI_Y]  = root_hi;
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
            num_reg  <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_num   = num_reg;

endmodule

// ----- design/qtoe_cell.sv -----
// one descent cell: picks the first child of the current tile that holds the box
module qtoe_cell #(
    parameter int MAX_LEVEL = qtoe_pkg::MAX_LEVEL_DEF,
    parameter int LEVEL     = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [qtoe_pkg::SIDE_W-1:0]          base_side,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  qtoe_pkg::item_t                      in_item,
    input  logic [qtoe_pkg::NUM_CNT-1:0][qtoe_pkg::SIDE_W+MAX_LEVEL-1:0] in_num,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qtoe_pkg::item_t                      out_item,
    output logic [qtoe_pkg::NUM_CNT-1:0][qtoe_pkg::SIDE_W+MAX_LEVEL-1:0] out_num
);
    import qtoe_pkg::*;

    localparam int NW = SIDE_W + MAX_LEVEL;
    // child side in numerator units
    localparam int SH = MAX_LEVEL - LEVEL - 1;

    logic                         valid_reg;
    item_t                        item_reg;
    item_t                        item_next;
    logic [NUM_CNT-1:0][NW-1:0]   num_reg;
    logic [NUM_CNT-1:0][NW-1:0]   num_next;
    logic [NW-1:0]                half;
    logic [NW-1:0]                mid_x;
    logic [NW-1:0]                mid_y;
    logic signed [REL_W-1:0]      lo_x_off;
    logic signed [REL_W-1:0]      hi_x_off;
    logic signed [REL_W-1:0]      mid_x_off;
    logic signed [REL_W-1:0]      lo_y_off;
    logic signed [REL_W-1:0]      hi_y_off;
    logic signed [REL_W-1:0]      mid_y_off;
    logic                         x_lo_ok;
    logic                         x_hi_ok;
    logic                         y_lo_ok;
    logic                         y_hi_ok;
    logic                         found;
    logic                         pick_hi_x;
    logic                         pick_hi_y;
    logic                         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // middle edges of the current tile
    assign half  = NW'(base_side) << SH;
    assign mid_x = in_num[NUM_LO_X] + half;
    assign mid_y = in_num[NUM_LO_Y] + half;

    // integer part of each edge numerator, as a signed offset
    assign lo_x_off  = $signed({2'b00, in_num[NUM_LO_X][NW-1:MAX_LEVEL]});
    assign hi_x_off  = $signed({2'b00, in_num[NUM_HI_X][NW-1:MAX_LEVEL]});
    assign mid_x_off = $signed({2'b00, mid_x[NW-1:MAX_LEVEL]});
    assign lo_y_off  = $signed({2'b00, in_num[NUM_LO_Y][NW-1:MAX_LEVEL]});
    assign hi_y_off  = $signed({2'b00, in_num[NUM_HI_Y][NW-1:MAX_LEVEL]});
    assign mid_y_off = $signed({2'b00, mid_y[NW-1:MAX_LEVEL]});

    // per-axis containment in the lower and upper half, edges inclusive
    assign x_lo_ok = (in_item.rel_min_x >= lo_x_off) && (in_item.rel_max_x <= mid_x_off);
    assign x_hi_ok = (in_item.rel_min_x >= mid_x_off) && (in_item.rel_max_x <= hi_x_off);
    assign y_lo_ok = (in_item.rel_min_y >= lo_y_off) && (in_item.rel_max_y <= mid_y_off);
    assign y_hi_ok = (in_item.rel_min_y >= mid_y_off) && (in_item.rel_max_y <= hi_y_off);

    // child order: low/low, high/low, low/high, high/high
    always_comb begin
        found     = 1'b1;
        pick_hi_x = 1'b0;
        pick_hi_y = 1'b0;
        if (x_lo_ok && y_lo_ok) begin
            pick_hi_x = 1'b0;
            pick_hi_y = 1'b0;
        end else if (x_hi_ok && y_lo_ok) begin
            pick_hi_x = 1'b1;
            pick_hi_y = 1'b0;
        end else if (x_lo_ok && y_hi_ok) begin
            pick_hi_x = 1'b0;
            pick_hi_y = 1'b1;
        end else if (x_hi_ok && y_hi_ok) begin
            pick_hi_x = 1'b1;
            pick_hi_y = 1'b1;
        end else begin
            found = 1'b0;
        end
    end

    // descend into the chosen child, or freeze once stopped
    always_comb begin
        item_next = in_item;
        num_next  = in_num;
        if (!in_item.done) begin
            if (found) begin
                item_next.tile_x = {in_item.tile_x[TILE_W-2:0], pick_hi_x};
                item_next.tile_y = {in_item.tile_y[TILE_W-2:0], pick_hi_y};
                item_next.level  = in_item.level + LVL_W'(1);
                if (pick_hi_x) begin
                    num_next[NUM_LO_X] = mid_x;
                end else begin
                    num_next[NUM_HI_X] = mid_x;
                end
                if (pick_hi_y) begin
                    num_next[NUM_LO_Y] = mid_y;
                end else begin
                    num_next[NUM_HI_Y] = mid_y;
                end
            end else begin
                item_next.done = 1'b1;
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
            num_reg  <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_num   = num_reg;

endmodule

// ----- design/quadtree_tile_of_extent.sv -----
// top level: configuration registers, entry stage and the chain of descent cells
//
// Finds the deepest quadtree tile that fully holds an axis-aligned box.
// Input stream s_*: one box per transaction, four signed Q16.16 coordinates.
// Output stream m_*: one result per box, in input order: tile column, tile
// row, level (0 is the root) and a flag set when the descent reached
// MAX_LEVEL.
// Configuration channel cfg_*: writes origin_x, origin_y and base_side by
// index and is always ready; the user must see that it is written only
// while no box is in flight, as the block itself does not enforce this.
// A box passes through one entry stage that subtracts the origin, then one
// cell per tree level, each taking the box one level down with an add and
// comparisons per axis. Throughput is one box per cycle unless the receiver
// stalls, since every cell holds its own box. Reset clears all stage valid
// bits and sets the three registers to zero. When the receiver stalls, the
// last stage holds its result and upstream stages keep filling any empty
// slots; s_tready drops only once every stage is full.
module quadtree_tile_of_extent #(
    parameter int MAX_LEVEL = qtoe_pkg::MAX_LEVEL_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qtoe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qtoe_pkg::COORD_W-1:0]       cfg_data,
    // input boxes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qtoe_pkg::S_DATA_W-1:0]      s_tdata,  // min_x, min_y, max_x, max_y
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qtoe_pkg::M_DATA_W-1:0]      m_tdata   // tile_x, tile_y, level, depth_capped, zero pad
);
    import qtoe_pkg::*;

    localparam int NW = SIDE_W + MAX_LEVEL;

    logic signed [COORD_W-1:0]   origin_x_reg;
    logic signed [COORD_W-1:0]   origin_y_reg;
    logic [SIDE_W-1:0]           base_side_reg;

    logic                        stg_valid [0:MAX_LEVEL];
    logic                        stg_ready [0:MAX_LEVEL];
    item_t                       stg_item  [0:MAX_LEVEL];
    logic [NUM_CNT-1:0][NW-1:0]  stg_num   [0:MAX_LEVEL];

    item_t                       res;
    logic                        depth_capped;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            base_side_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:  origin_x_reg  <= $signed(cfg_data);
                CFG_ORIGIN_Y:  origin_y_reg  <= $signed(cfg_data);
                CFG_BASE_SIDE: base_side_reg <= cfg_data[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // entry stage
    qtoe_entry #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .base_side (base_side_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .min_x     ($signed(s_tdata[COORD_W-1:0])),
        .min_y     ($signed(s_tdata[2*COORD_W-1:COORD_W])),
        .max_x     ($signed(s_tdata[3*COORD_W-1:2*COORD_W])),
        .max_y     ($signed(s_tdata[4*COORD_W-1:3*COORD_W])),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0]),
        .out_num   (stg_num[0])
    );

    // one cell per tree level
    for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_cell
        qtoe_cell #(
            .MAX_LEVEL (MAX_LEVEL),
            .LEVEL     (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .base_side (base_side_reg),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .in_num    (stg_num[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1]),
            .out_num   (stg_num[k+1])
        );
    end

    // result packing: a descent that never stopped ran to the last level
    assign res          = stg_item[MAX_LEVEL];
    assign depth_capped = !res.done;
    assign stg_ready[MAX_LEVEL] = m_tready;
    assign m_tvalid = stg_valid[MAX_LEVEL];
    assign m_tdata  = {{(M_DATA_W - 2*TILE_W - LVL_W - 1){1'b0}},
                       depth_capped, res.level, res.tile_y, res.tile_x};

`ifndef NO_ASSERTIONS
    // the capped flag and the reported level agree
    a_cap_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*TILE_W+LVL_W] == (m_tdata[2*TILE_W +: LVL_W] == LVL_W'(MAX_LEVEL))))
        else $error("depth_capped does not match level");

    // a tile index never exceeds the width of its level
    a_tile_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2*TILE_W +: LVL_W] < LVL_W'(TILE_W)) |->
        ((m_tdata[TILE_W-1:0] >> m_tdata[2*TILE_W +: LVL_W]) == '0 &&
         (m_tdata[2*TILE_W-1:TILE_W] >> m_tdata[2*TILE_W +: LVL_W]) == '0))
        else $error("tile index out of range for its level");

    // input backpressure only when the chain is full up to the output
    a_full_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the chain has room");
`endif

endmodule

// ----- verif/tb.sv -----
// testbench for quadtree_tile_of_extent: directed and random boxes checked against a tile-descent predictor
module tb;
    import qtoe_pkg::*;

    localparam int MAX_LVL = MAX_LEVEL_DEF;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -(64'sd2147483648);
    // directed tree: origin (-8.0, 4.0), side 16.0
    localparam longint OX_A = -(64'sd524288);
    localparam longint OY_A = 64'sd262144;
    localparam longint SIDE_A = 64'sd1048576;

    // one expected result
    typedef struct packed {
        logic [TILE_W-1:0] tile_x;
        logic [TILE_W-1:0] tile_y;
        logic [LVL_W-1:0]  level;
        logic              capped;
    } tile_t;

    // predicts the deepest holding tile and keeps the expected results in order
    class tile_scoreboard;
        longint org_x;
        longint org_y;
        longint side;
        tile_t  pending[$];
        int     errors;
        int     results;
        int     root_hits;
        int     capped_hits;

        function void set_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
            case (idx)
                CFG_ORIGIN_X: org_x = longint'($signed(val));
                CFG_ORIGIN_Y: org_y = longint'($signed(val));
                CFG_BASE_SIDE: side = longint'(val[SIDE_W-1:0]);
                default: ;
            endcase
        endfunction

        // lower edge of tile idx at level lvl, exact in 64 bits
        function longint edge_at(longint org, longint idx, int lvl);
            return org + ((idx * side) >>> lvl);
        endfunction

        function tile_t deepest_tile(logic [S_DATA_W-1:0] box);
            longint bx0, by0, bx1, by1, x, y, cx, cy;
            int     lvl;
            bit     found;
            bit     stop;
            tile_t  r;
            bx0 = longint'($signed(box[31:0]));
            by0 = longint'($signed(box[63:32]));
            bx1 = longint'($signed(box[95:64]));
            by1 = longint'($signed(box[127:96]));
            x = 0;
            y = 0;
            lvl = 0;
            stop = 0;
            // children tried in z order, first holder wins
            while (!stop && lvl < MAX_LVL) begin
                found = 0;
                for (int c = 0; c < 4; c++) begin
                    cx = 2 * x + (c & 1);
                    cy = 2 * y + (c >> 1);
                    if (!found && edge_at(org_x, cx, lvl + 1) <= bx0
                            && edge_at(org_y, cy, lvl + 1) <= by0
                            && edge_at(org_x, cx + 1, lvl + 1) >= bx1
                            && edge_at(org_y, cy + 1, lvl + 1) >= by1) begin
                        x = cx;
                        y = cy;
                        found = 1;
                    end
                end
                if (found) lvl++;
                else stop = 1;
            end
            r.tile_x = x[TILE_W-1:0];
            r.tile_y = y[TILE_W-1:0];
            r.level = lvl[LVL_W-1:0];
            r.capped = (lvl >= MAX_LVL);
            return r;
        endfunction

        function void note_box(logic [S_DATA_W-1:0] box);
            pending.push_back(deepest_tile(box));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            tile_t want;
            results++;
            if (pending.size() == 0) begin
                $error("result transaction with no box pending: %h", d);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("tile_x", want.tile_x, d[15:0]);
            compare_field("tile_y", want.tile_y, d[31:16]);
            compare_field("level", want.level, d[36:32]);
            compare_field("depth_capped", want.capped, d[37]);
            if (want.level == 0) root_hits++;
            if (want.capped) capped_hits++;
        endfunction

        function logic [COORD_W-1:0] clamp(longint v);
            if (v > COORD_MAX) return 32'h7fffffff;
            if (v < COORD_MIN) return 32'h80000000;
            return v[COORD_W-1:0];
        endfunction

        function logic [S_DATA_W-1:0] pack_box(longint x0, longint y0, longint x1, longint y1);
            return {clamp(y1), clamp(x1), clamp(y0), clamp(x0)};
        endfunction

        // value in [a, b], endpoints favored
        function longint pick_in(longint a, longint b);
            bit [63:0] r;
            bit [63:0] span;
            r = {$urandom(), $urandom()};
            span = b - a + 1;
            case ($urandom_range(0, 3))
                0: return a;
                1: return b;
                default: return a + longint'(r % span);
            endcase
        endfunction

        // span inside tile idx on one axis, optionally pushed just past an edge
        function void pick_span(longint org, int lvl, longint idx, bit straddle,
                                output longint lo, output longint hi);
            longint e0, e1;
            e0 = edge_at(org, idx, lvl);
            e1 = edge_at(org, idx + 1, lvl);
            lo = pick_in(e0, e1);
            hi = pick_in(lo, e1);
            if (straddle) begin
                if ($urandom_range(0, 1)) lo = e0 - $urandom_range(1, 4);
                else hi = e1 + $urandom_range(1, 4);
            end
        endfunction

        // box inside a random tile; straddling or inverted on request
        function logic [S_DATA_W-1:0] tile_box(bit straddle, bit invert);
            longint x0, x1, y0, y1, tmp;
            int     lvl;
            lvl = $urandom_range(0, MAX_LVL);
            pick_span(org_x, lvl, $urandom_range(0, (1 << lvl) - 1), straddle, x0, x1);
            pick_span(org_y, lvl, $urandom_range(0, (1 << lvl) - 1), straddle, y0, y1);
            if (invert) begin
                tmp = x0;
                x0 = x1 + 1;
                x1 = tmp;
            end
            return pack_box(x0, y0, x1, y1);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // min_x, min_y, max_x, max_y
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // tile_x, tile_y, level, depth_capped, zero pad

    tile_scoreboard sb = new();
    int burst_left = 0;
    int settings = 0;

    quadtree_tile_of_extent #(.MAX_LEVEL(MAX_LVL)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver: windows of steady, random, alternating or long-stall backpressure
    initial begin
        int mode;
        int span;
        int cnt;
        m_tready = 1'b0;
        cnt = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span) begin
                @(negedge aclk);
                cnt++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= cnt[0];
                    default: m_tready <= ((cnt % 24) >= 16);
                endcase
            end
        end
    end

    // sender in bursts of random length with random gaps
    task automatic send_box(input logic [S_DATA_W-1:0] box);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= box;
        do @(posedge aclk); while (!s_tready);
        sb.note_box(box);
        burst_left--;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // close any open burst and wait for every result to come back
    task automatic drain;
        if (s_tvalid) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_tree(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                            input logic [COORD_W-1:0] side);
        drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_BASE_SIDE, side);
        settings++;
    endtask

    // mostly in-tile boxes, some straddling an edge, some noise or inverted
    task automatic run_random(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 7) send_box(sb.tile_box(1'b0, 1'b0));
            else if (r < 9) send_box(sb.tile_box(1'b1, 1'b0));
            else if ($urandom_range(0, 1)) send_box({$urandom(), $urandom(), $urandom(), $urandom()});
            else send_box(sb.tile_box(1'b0, 1'b1));
        end
    endtask

    // main sequence
    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero side after reset: only the origin point descends
        send_box(sb.pack_box(0, 0, 0, 0));
        send_box(sb.pack_box(0, 0, 1, 0));
        send_box(sb.pack_box(-1, 0, 0, 0));

        // directed tree
        set_tree(OX_A[31:0], OY_A[31:0], SIDE_A[31:0]);
        send_box(sb.pack_box(OX_A, OY_A, OX_A + SIDE_A, OY_A + SIDE_A));
        send_box(sb.pack_box(OX_A, OY_A, OX_A, OY_A));
        send_box(sb.pack_box(OX_A + SIDE_A, OY_A + SIDE_A, OX_A + SIDE_A, OY_A + SIDE_A));
        send_box(sb.pack_box(OX_A + SIDE_A / 2, OY_A + SIDE_A / 2,
                             OX_A + SIDE_A / 2, OY_A + SIDE_A / 2));
        // straddles the root center
        send_box(sb.pack_box(OX_A + SIDE_A / 2 - 7, OY_A + SIDE_A / 2 - 7,
                             OX_A + SIDE_A / 2 + 9, OY_A + SIDE_A / 2 + 9));
        // exactly the second child of the root
        send_box(sb.pack_box(OX_A + SIDE_A / 2, OY_A, OX_A + SIDE_A, OY_A + SIDE_A / 2));
        send_box(sb.pack_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        // inverted box is held by every tile
        send_box(sb.pack_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        // inside one leaf tile
        send_box(sb.pack_box(OX_A + 81, OY_A + 145, OX_A + 95, OY_A + 159));
        // outside the root entirely
        send_box(sb.pack_box(OX_A - 100, OY_A - 100, OX_A - 50, OY_A - 50));
        send_box(sb.pack_box(OX_A, COORD_MAX, OX_A + 1, COORD_MAX));
        send_box(sb.pack_box(OX_A + SIDE_A, OY_A, OX_A + SIDE_A + 1, OY_A));

        // random phases, extremes included
        set_tree(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);
        run_random(130);
        set_tree(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        run_random(130);
        set_tree(32'h7fff_ffff, 32'h7fff_ffff, $urandom_range(0, 32'h7fff_ffff));
        run_random(130);
        set_tree($urandom(), $urandom(), 32'h0000_0001);
        run_random(130);
        set_tree($urandom(), $urandom(), $urandom_range(0, 1000));
        run_random(130);
        set_tree($urandom(), $urandom(), $urandom_range(0, 32'h7fff_ffff));
        run_random(130);
        set_tree($urandom(), $urandom(), 32'h0000_0000);
        run_random(130);
        set_tree($urandom(), $urandom(), $urandom_range(32'h0001_0000, 32'h0100_0000));
        run_random(130);

        drain();
        repeat (MAX_LVL + 8) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("checked %0d tile results over %0d tree settings", sb.results, settings);
        $display("%0d answered at the root, %0d stopped at the depth cap",
                 sb.root_hits, sb.capped_hits);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

endmodule
